### src/cc2_pkg.sv
// shared widths, payload types and pipeline structs for the circumcenter block
package cc2_pkg;

  localparam int CoordBits = 32;
  localparam int DiffW     = CoordBits + 1;
  localparam int ProdW     = 2 * DiffW;
  localparam int SqW       = ProdW + 1;
  localparam int DenW      = ProdW + 2;
  localparam int NumW      = DiffW + SqW + 1;
  localparam int QuoW      = CoordBits + 1;
  localparam int SumW      = CoordBits + 2;
  localparam int SqLoW     = SqW / 2;
  localparam int SqHiW     = SqW - SqLoW;

  typedef struct packed {
    logic signed [CoordBits-1:0] ax;
    logic signed [CoordBits-1:0] ay;
    logic signed [CoordBits-1:0] bx;
    logic signed [CoordBits-1:0] by_coord;
    logic signed [CoordBits-1:0] cx;
    logic signed [CoordBits-1:0] cy;
  } cc2_in_t;

  typedef struct packed {
    logic signed [CoordBits-1:0] vert_x;
    logic signed [CoordBits-1:0] vert_y;
    logic                        valid_res;
  } cc2_out_t;

  typedef struct packed {
    logic signed [DiffW-1:0]     d1x;
    logic signed [DiffW-1:0]     d1y;
    logic signed [DiffW-1:0]     d2x;
    logic signed [DiffW-1:0]     d2y;
    logic signed [DenW-1:0]      den;
    logic        [SqW-1:0]       s1;
    logic        [SqW-1:0]       s2;
    logic signed [CoordBits-1:0] ax;
    logic signed [CoordBits-1:0] ay;
    logic signed [SumW-1:0]      sumx;
    logic signed [SumW-1:0]      sumy;
  } cc2_geom_t;

  typedef struct packed {
    logic        [NumW-1:0]      an;
    logic        [DenW-1:0]      ad;
    logic                        neg;
    logic signed [CoordBits-1:0] addend;
    logic                        tag;
  } cc2_divop_t;

  typedef struct packed {
    logic        [DenW-1:0]      rem;
    logic        [QuoW-1:0]      nlow;
    logic        [QuoW-1:0]      quo;
    logic        [DenW-1:0]      ad;
    logic                        neg;
    logic                        ovf;
    logic signed [CoordBits-1:0] addend;
    logic                        tag;
  } cc2_divst_t;

endpackage

### src/cc2_geom.sv
// edge vectors, their products, twice the cross product, squared lengths and coordinate sums
module cc2_geom (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  cc2_pkg::cc2_in_t   pt_i,
  output logic               valid_o,
  output cc2_pkg::cc2_geom_t geom_o
);

  localparam int DiffW = cc2_pkg::DiffW;
  localparam int ProdW = cc2_pkg::ProdW;
  localparam int SqW   = cc2_pkg::SqW;
  localparam int DenW  = cc2_pkg::DenW;
  localparam int SumW  = cc2_pkg::SumW;
  localparam int CB    = cc2_pkg::CoordBits;

  logic [2:0] vld_q;

  logic signed [DiffW-1:0] d1x_q, d1y_q, d2x_q, d2y_q;
  logic signed [DiffW-1:0] e1x_q, e1y_q, e2x_q, e2y_q;
  logic signed [CB-1:0]    ax1_q, ay1_q, ax2_q, ay2_q;
  logic signed [SumW-1:0]  sx1_q, sy1_q, sx2_q, sy2_q;
  logic signed [ProdW-1:0] cr1_q, cr2_q, q11_q, q12_q, q21_q, q22_q;
  cc2_pkg::cc2_geom_t      geom_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    // stage 1: differences and coordinate sums
    d1x_q <= DiffW'(pt_i.bx) - DiffW'(pt_i.ax);
    d1y_q <= DiffW'(pt_i.by_coord) - DiffW'(pt_i.ay);
    d2x_q <= DiffW'(pt_i.cx) - DiffW'(pt_i.ax);
    d2y_q <= DiffW'(pt_i.cy) - DiffW'(pt_i.ay);
    ax1_q <= pt_i.ax;
    ay1_q <= pt_i.ay;
    sx1_q <= SumW'(pt_i.ax) + SumW'(pt_i.bx) + SumW'(pt_i.cx);
    sy1_q <= SumW'(pt_i.ay) + SumW'(pt_i.by_coord) + SumW'(pt_i.cy);
    // stage 2: products
    cr1_q <= d1x_q * d2y_q;
    cr2_q <= d1y_q * d2x_q;
    q11_q <= d1x_q * d1x_q;
    q12_q <= d1y_q * d1y_q;
    q21_q <= d2x_q * d2x_q;
    q22_q <= d2y_q * d2y_q;
    e1x_q <= d1x_q;
    e1y_q <= d1y_q;
    e2x_q <= d2x_q;
    e2y_q <= d2y_q;
    ax2_q <= ax1_q;
    ay2_q <= ay1_q;
    sx2_q <= sx1_q;
    sy2_q <= sy1_q;
    // stage 3: determinant and squared lengths
    geom_q.den  <= (DenW'(cr1_q) - DenW'(cr2_q)) <<< 1;
    geom_q.s1   <= SqW'($unsigned(q11_q)) + SqW'($unsigned(q12_q));
    geom_q.s2   <= SqW'($unsigned(q21_q)) + SqW'($unsigned(q22_q));
    geom_q.d1x  <= e1x_q;
    geom_q.d1y  <= e1y_q;
    geom_q.d2x  <= e2x_q;
    geom_q.d2y  <= e2y_q;
    geom_q.ax   <= ax2_q;
    geom_q.ay   <= ay2_q;
    geom_q.sumx <= sx2_q;
    geom_q.sumy <= sy2_q;
  end

  assign valid_o = vld_q[2];
  assign geom_o  = geom_q;

endmodule

### src/cc2_numer.sv
// numerators from split products, then divider operands for both axes
module cc2_numer (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  cc2_pkg::cc2_geom_t  geom_i,
  output logic                valid_o,
  output cc2_pkg::cc2_divop_t opx_o,
  output cc2_pkg::cc2_divop_t opy_o
);

  localparam int DiffW = cc2_pkg::DiffW;
  localparam int DenW  = cc2_pkg::DenW;
  localparam int NumW  = cc2_pkg::NumW;
  localparam int SumW  = cc2_pkg::SumW;
  localparam int SqW   = cc2_pkg::SqW;
  localparam int SqLoW = cc2_pkg::SqLoW;
  localparam int SqHiW = cc2_pkg::SqHiW;
  localparam int CB    = cc2_pkg::CoordBits;
  localparam int PLoW  = DiffW + SqLoW + 1;
  localparam int PHiW  = DiffW + SqHiW + 1;

  logic [3:0] vld_q;

  logic signed [SqLoW:0] s1lo, s2lo;
  logic signed [SqHiW:0] s1hi, s2hi;

  assign s1lo = {1'b0, geom_i.s1[SqLoW-1:0]};
  assign s2lo = {1'b0, geom_i.s2[SqLoW-1:0]};
  assign s1hi = {1'b0, geom_i.s1[SqW-1:SqLoW]};
  assign s2hi = {1'b0, geom_i.s2[SqW-1:SqLoW]};

  logic signed [PLoW-1:0] ax1lo_q, ax2lo_q, ay1lo_q, ay2lo_q;
  logic signed [PHiW-1:0] ax1hi_q, ax2hi_q, ay1hi_q, ay2hi_q;
  logic signed [NumW-1:0] tx1_q, tx2_q, ty1_q, ty2_q, nx_q, ny_q;
  logic signed [DenW-1:0] den4_q, den5_q, den6_q;
  logic signed [SumW-1:0] sx4_q, sy4_q, sx5_q, sy5_q, sx6_q, sy6_q;
  logic signed [CB-1:0]   a4x_q, a4y_q, a5x_q, a5y_q, a6x_q, a6y_q;
  logic                   deg4_q, deg5_q, deg6_q;
  cc2_pkg::cc2_divop_t    opx_q, opy_q;

  logic [NumW-1:0] sxa, sya, nxa, nya;
  logic [DenW-1:0] dena;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[2:0], valid_i};
    end
  end

  always_comb begin
    sxa  = sx6_q[SumW-1] ? NumW'(-NumW'(sx6_q)) : NumW'(sx6_q);
    sya  = sy6_q[SumW-1] ? NumW'(-NumW'(sy6_q)) : NumW'(sy6_q);
    nxa  = nx_q[NumW-1] ? $unsigned(-nx_q) : $unsigned(nx_q);
    nya  = ny_q[NumW-1] ? $unsigned(-ny_q) : $unsigned(ny_q);
    dena = den6_q[DenW-1] ? $unsigned(-den6_q) : $unsigned(den6_q);
  end

  always_ff @(posedge clk_i) begin
    // stage 4: partial products over the halves of the squared lengths
    ax1lo_q <= geom_i.d2y * s1lo;
    ax1hi_q <= geom_i.d2y * s1hi;
    ax2lo_q <= geom_i.d1y * s2lo;
    ax2hi_q <= geom_i.d1y * s2hi;
    ay1lo_q <= geom_i.d1x * s2lo;
    ay1hi_q <= geom_i.d1x * s2hi;
    ay2lo_q <= geom_i.d2x * s1lo;
    ay2hi_q <= geom_i.d2x * s1hi;
    den4_q  <= geom_i.den;
    deg4_q  <= (geom_i.den == '0);
    sx4_q   <= geom_i.sumx;
    sy4_q   <= geom_i.sumy;
    a4x_q   <= geom_i.ax;
    a4y_q   <= geom_i.ay;
    // stage 5: full products
    tx1_q  <= (NumW'(ax1hi_q) <<< SqLoW) + NumW'(ax1lo_q);
    tx2_q  <= (NumW'(ax2hi_q) <<< SqLoW) + NumW'(ax2lo_q);
    ty1_q  <= (NumW'(ay1hi_q) <<< SqLoW) + NumW'(ay1lo_q);
    ty2_q  <= (NumW'(ay2hi_q) <<< SqLoW) + NumW'(ay2lo_q);
    den5_q <= den4_q;
    deg5_q <= deg4_q;
    sx5_q  <= sx4_q;
    sy5_q  <= sy4_q;
    a5x_q  <= a4x_q;
    a5y_q  <= a4y_q;
    // stage 6: numerators
    nx_q   <= tx1_q - tx2_q;
    ny_q   <= ty1_q - ty2_q;
    den6_q <= den5_q;
    deg6_q <= deg5_q;
    sx6_q  <= sx5_q;
    sy6_q  <= sy5_q;
    a6x_q  <= a5x_q;
    a6y_q  <= a5y_q;
    // stage 7: magnitudes and signs, centroid when degenerate
    if (deg6_q) begin
      opx_q.an     <= sxa;
      opx_q.ad     <= DenW'(3);
      opx_q.neg    <= sx6_q[SumW-1];
      opx_q.addend <= '0;
      opx_q.tag    <= 1'b0;
      opy_q.an     <= sya;
      opy_q.ad     <= DenW'(3);
      opy_q.neg    <= sy6_q[SumW-1];
      opy_q.addend <= '0;
      opy_q.tag    <= 1'b0;
    end else begin
      opx_q.an     <= nxa;
      opx_q.ad     <= dena;
      opx_q.neg    <= nx_q[NumW-1] ^ den6_q[DenW-1];
      opx_q.addend <= a6x_q;
      opx_q.tag    <= 1'b1;
      opy_q.an     <= nya;
      opy_q.ad     <= dena;
      opy_q.neg    <= ny_q[NumW-1] ^ den6_q[DenW-1];
      opy_q.addend <= a6y_q;
      opy_q.tag    <= 1'b1;
    end
  end

  assign valid_o = vld_q[3];
  assign opx_o   = opx_q;
  assign opy_o   = opy_q;

endmodule

### src/cc2_div_step.sv
// one restoring division step, registered
module cc2_div_step (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  cc2_pkg::cc2_divst_t st_i,
  output logic                valid_o,
  output cc2_pkg::cc2_divst_t st_o
);

  localparam int DenW = cc2_pkg::DenW;
  localparam int QuoW = cc2_pkg::QuoW;

  logic                vld_q;
  cc2_pkg::cc2_divst_t st_q;
  cc2_pkg::cc2_divst_t st_d;
  logic [DenW:0]       trial;
  logic                ge;

  always_comb begin
    trial = {st_i.rem, st_i.nlow[QuoW-1]};
    ge    = (trial >= {1'b0, st_i.ad});
    st_d      = st_i;
    st_d.rem  = ge ? DenW'(trial - {1'b0, st_i.ad}) : DenW'(trial);
    st_d.nlow = st_i.nlow << 1;
    st_d.quo  = {st_i.quo[QuoW-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    st_q <= st_d;
  end

  assign valid_o = vld_q;
  assign st_o    = st_q;

endmodule

### src/cc2_divider.sv
// pipelined rounding divider with range check, offset add and saturation
module cc2_divider (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  cc2_pkg::cc2_divop_t         op_i,
  output logic                        valid_o,
  output logic signed [cc2_pkg::CoordBits-1:0] vert_o,
  output logic                        tag_o
);

  localparam int DenW = cc2_pkg::DenW;
  localparam int NumW = cc2_pkg::NumW;
  localparam int QuoW = cc2_pkg::QuoW;
  localparam int CB   = cc2_pkg::CoordBits;
  localparam int SatW = QuoW + 3;

  logic                vld0_q;
  cc2_pkg::cc2_divst_t st0_q;
  logic [DenW-1:0]     an_hi;
  logic                ovf;

  logic                vld_s [QuoW+1];
  cc2_pkg::cc2_divst_t st_s  [QuoW+1];

  assign an_hi = op_i.an[NumW-1:QuoW];
  assign ovf   = (an_hi >= op_i.ad);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld0_q <= 1'b0;
    end else begin
      vld0_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    st0_q.rem    <= ovf ? '0 : an_hi;
    st0_q.nlow   <= op_i.an[QuoW-1:0];
    st0_q.quo    <= '0;
    st0_q.ad     <= op_i.ad;
    st0_q.neg    <= op_i.neg;
    st0_q.ovf    <= ovf;
    st0_q.addend <= op_i.addend;
    st0_q.tag    <= op_i.tag;
  end

  assign vld_s[0] = vld0_q;
  assign st_s[0]  = st0_q;

  for (genvar g = 0; g < QuoW; g++) begin : g_step
    cc2_div_step u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (vld_s[g]),
      .st_i    (st_s[g]),
      .valid_o (vld_s[g+1]),
      .st_o    (st_s[g+1])
    );
  end

  cc2_pkg::cc2_divst_t fin;
  assign fin = st_s[QuoW];

  logic                  rnd;
  logic [QuoW:0]         qmag;
  logic signed [QuoW+1:0] qpos;

  assign rnd  = ({fin.rem, 1'b0} >= {1'b0, fin.ad});
  assign qmag = (QuoW+1)'(fin.quo) + (QuoW+1)'(rnd);
  assign qpos = $signed({1'b0, qmag});

  logic                   vld1_q, vld2_q;
  logic signed [QuoW+1:0] qs_q;
  logic                   ovf1_q, neg1_q, tag1_q, tag2_q;
  logic signed [CB-1:0]   add1_q, vert_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
    end else begin
      vld1_q <= vld_s[QuoW];
      vld2_q <= vld1_q;
    end
  end

  logic signed [SatW-1:0] sum, vmax, vmin;

  assign vmax = $signed({{(SatW-CB+1){1'b0}}, {(CB-1){1'b1}}});
  assign vmin = ~vmax;
  assign sum  = SatW'(qs_q) + SatW'(add1_q);

  always_ff @(posedge clk_i) begin
    qs_q   <= fin.neg ? -qpos : qpos;
    ovf1_q <= fin.ovf;
    neg1_q <= fin.neg;
    add1_q <= fin.addend;
    tag1_q <= fin.tag;
    if (ovf1_q) begin
      vert_q <= neg1_q ? CB'(vmin) : CB'(vmax);
    end else if (sum > vmax) begin
      vert_q <= CB'(vmax);
    end else if (sum < vmin) begin
      vert_q <= CB'(vmin);
    end else begin
      vert_q <= CB'(sum);
    end
    tag2_q <= tag1_q;
  end

  assign valid_o = vld2_q;
  assign vert_o  = vert_q;
  assign tag_o   = tag2_q;

endmodule

### src/circumcenter_2d.sv
// top level: triangle circumcenter in signed fixed point, one triangle per cycle
//
//   channel   ports                    transfer when
//   command   start, busy, in_i        start high, busy low at a clock edge
//   result    done_o, res_o            done_o high for one cycle
//
// one triangle enters per cycle; the result passes through the geometry and numerator
// stages and then through the one-bit-per-stage divider
// busy stays low: the pipeline never stalls and the receiver takes every result
// reset clears only the stage valid bits; no clearing pass is needed
module circumcenter_2d (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  cc2_pkg::cc2_in_t  in_i,
  output logic              done_o,
  output cc2_pkg::cc2_out_t res_o
);

  localparam int unsigned Lat = cc2_pkg::QuoW + 10;

  logic                accept;
  logic                gvld, nvld, xvld, yvld, xtag, ytag;
  cc2_pkg::cc2_geom_t  geom;
  cc2_pkg::cc2_divop_t opx, opy;
  logic signed [cc2_pkg::CoordBits-1:0] vx, vy;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  cc2_geom u_geom (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (accept),
    .pt_i    (in_i),
    .valid_o (gvld),
    .geom_o  (geom)
  );

  cc2_numer u_numer (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (gvld),
    .geom_i  (geom),
    .valid_o (nvld),
    .opx_o   (opx),
    .opy_o   (opy)
  );

  cc2_divider u_div_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (nvld),
    .op_i    (opx),
    .valid_o (xvld),
    .vert_o  (vx),
    .tag_o   (xtag)
  );

  cc2_divider u_div_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (nvld),
    .op_i    (opy),
    .valid_o (yvld),
    .vert_o  (vy),
    .tag_o   (ytag)
  );

  assign done_o          = xvld;
  assign res_o.vert_x    = vx;
  assign res_o.vert_y    = vy;
  assign res_o.valid_res = xtag;

`ifndef SYNTHESIS
  a_lanes_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    xvld == yvld) else $error("axis lanes out of step");

  a_tags_agree: assert property (@(posedge clk_i) disable iff (!rst_ni)
    xvld |-> (xtag == ytag)) else $error("axis lanes disagree on degeneracy");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##Lat done_o) else $error("transfer produced no result in time");
`endif

endmodule

### verif/tb_circumcenter_2d.sv
// self-checking testbench for circumcenter_2d: directed table plus random triangles
`timescale 1ns / 1ps

module tb_circumcenter_2d;

  localparam int NumRandom = 1800;
  localparam int DrainCycles = 60;
  localparam logic signed [31:0] CMax = 32'sh7fffffff;
  localparam logic signed [31:0] CMin = 32'sh80000000;

  typedef logic signed [255:0] wide_t;

  typedef struct {
    cc2_pkg::cc2_in_t  tri_in;
    logic              fixed;
    cc2_pkg::cc2_out_t res;
  } row_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  cc2_pkg::cc2_in_t  in_i = '0;
  logic              done_o;
  cc2_pkg::cc2_out_t res_o;

  cc2_pkg::cc2_out_t pending_q[$];
  int       errors = 0;
  int       n_sent = 0;
  int       n_degen = 0;
  int       n_sat = 0;

  circumcenter_2d dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .in_i   (in_i),
    .done_o (done_o),
    .res_o  (res_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic logic signed [31:0] sat_coord(wide_t v);
    if (v > wide_t'(CMax)) return CMax;
    if (v < wide_t'(CMin)) return CMin;
    return v[31:0];
  endfunction

  function automatic wide_t div_round(wide_t n, wide_t d);
    wide_t an, ad, q, r;
    an = (n < 0) ? -n : n;
    ad = (d < 0) ? -d : d;
    q = an / ad;
    r = an % ad;
    if ((r <<< 1) >= ad) q = q + 1;
    return ((n < 0) != (d < 0)) ? -q : q;
  endfunction

  function automatic logic signed [31:0] third_round(logic signed [63:0] s);
    logic [63:0] m;
    logic [63:0] q;
    m = (s < 0) ? -s : s;
    q = (m + 1) / 3;
    return (s < 0) ? -$signed(q) : $signed(q);
  endfunction

  function automatic cc2_pkg::cc2_out_t circumcenter(cc2_pkg::cc2_in_t t);
    wide_t d1x, d1y, d2x, d2y, den, s1, s2, nx, ny, vx, vy;
    cc2_pkg::cc2_out_t o;
    d1x = wide_t'(t.bx) - wide_t'(t.ax);
    d1y = wide_t'(t.by_coord) - wide_t'(t.ay);
    d2x = wide_t'(t.cx) - wide_t'(t.ax);
    d2y = wide_t'(t.cy) - wide_t'(t.ay);
    den = 2 * (d1x * d2y - d1y * d2x);
    if (den == 0) begin
      o.vert_x = third_round(64'(t.ax) + 64'(t.bx) + 64'(t.cx));
      o.vert_y = third_round(64'(t.ay) + 64'(t.by_coord) + 64'(t.cy));
      o.valid_res = 1'b0;
    end else begin
      s1 = d1x * d1x + d1y * d1y;
      s2 = d2x * d2x + d2y * d2y;
      nx = d2y * s1 - d1y * s2;
      ny = d1x * s2 - d2x * s1;
      vx = div_round(nx, den) + wide_t'(t.ax);
      vy = div_round(ny, den) + wide_t'(t.ay);
      o.vert_x = sat_coord(vx);
      o.vert_y = sat_coord(vy);
      o.valid_res = 1'b1;
    end
    return o;
  endfunction

  task automatic send_triangle(cc2_pkg::cc2_in_t t, logic fixed, cc2_pkg::cc2_out_t res,
                               int gap);
    cc2_pkg::cc2_out_t e;
    in_i <= t;
    start <= 1'b1;
    do @(posedge clk_i); while (busy);
    e = fixed ? res : circumcenter(t);
    pending_q.push_back(e);
    n_sent++;
    if (!e.valid_res) n_degen++;
    if (e.valid_res && (e.vert_x == CMax || e.vert_x == CMin)) n_sat++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  function automatic logic signed [31:0] rnd_coord(int mode);
    case (mode)
      0: return $signed($urandom());
      1: return $signed($urandom_range(2 * 65536)) - 65536;
      2: return ($urandom_range(1)) ? CMax : CMin;
      default: return $signed($urandom_range(2048)) - 1024;
    endcase
  endfunction

  function automatic cc2_pkg::cc2_in_t rnd_triangle();
    cc2_pkg::cc2_in_t t;
    int mode;
    int k;
    mode = $urandom_range(3);
    t.ax = rnd_coord(mode); t.ay = rnd_coord(mode);
    t.bx = rnd_coord(mode); t.by_coord = rnd_coord(mode);
    t.cx = rnd_coord(mode); t.cy = rnd_coord(mode);
    case ($urandom_range(9))
      0: begin
        k = $signed($urandom_range(8)) - 4;
        t.bx = $signed($urandom_range(2000)) - 1000;
        t.by_coord = $signed($urandom_range(2000)) - 1000;
        t.ax = $signed($urandom_range(2000)) - 1000;
        t.ay = $signed($urandom_range(2000)) - 1000;
        t.cx = t.ax + k * (t.bx - t.ax);
        t.cy = t.ay + k * (t.by_coord - t.ay);
      end
      1: begin
        t.bx = t.ax; t.by_coord = t.ay;
      end
      2: begin
        t.cx = t.bx; t.cy = t.by_coord;
      end
      default: ;
    endcase
    return t;
  endfunction

  always @(posedge clk_i) begin
    cc2_pkg::cc2_out_t e;
    if (rst_ni && done_o) begin
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result x=%h y=%h v=%b", $time,
                 res_o.vert_x, res_o.vert_y, res_o.valid_res);
        errors++;
      end else begin
        e = pending_q.pop_front();
        if (res_o.vert_x !== e.vert_x) begin
          $display("%0t: vert_x expected %h actual %h", $time, e.vert_x, res_o.vert_x);
          errors++;
        end
        if (res_o.vert_y !== e.vert_y) begin
          $display("%0t: vert_y expected %h actual %h", $time, e.vert_y, res_o.vert_y);
          errors++;
        end
        if (res_o.valid_res !== e.valid_res) begin
          $display("%0t: valid_res expected %b actual %b", $time, e.valid_res,
                   res_o.valid_res);
          errors++;
        end
      end
    end
  end

  initial begin
    #5ms;
    $display("** circumcenter_2d: FAILED **");
    $finish;
  end

  initial begin
    row_t rows[$];
    row_t r;
    cc2_pkg::cc2_in_t t;
    int w;

    r.fixed = 1'b1;
    r.tri_in = '0; r.res = '{32'sd0, 32'sd0, 1'b0}; rows.push_back(r);
    r.tri_in = '{32'sd0, 32'sd0, 32'sd2, 32'sd0, 32'sd0, 32'sd2};
    r.res = '{32'sd1, 32'sd1, 1'b1}; rows.push_back(r);
    r.tri_in = '{CMax, CMax, CMax, CMax, CMax, CMax};
    r.res = '{CMax, CMax, 1'b0}; rows.push_back(r);
    r.tri_in = '{CMin, CMin, CMin, CMin, CMin, CMin};
    r.res = '{CMin, CMin, 1'b0}; rows.push_back(r);
    r.tri_in = '{32'sd0, 32'sd0, 32'sd1, 32'sd1, 32'sd2, 32'sd2};
    r.res = '{32'sd1, 32'sd1, 1'b0}; rows.push_back(r);
    r.tri_in = '{32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd1, 32'sd1};
    r.res = '{32'sd0, 32'sd0, 1'b0}; rows.push_back(r);
    r.tri_in = '{32'sd0, 32'sd0, -32'sd1, -32'sd1, -32'sd1, -32'sd1};
    r.res = '{-32'sd1, -32'sd1, 1'b0}; rows.push_back(r);
    r.fixed = 1'b0;
    r.res = '0;
    r.tri_in = '{CMin, CMin, CMax, CMin, CMin, CMax}; rows.push_back(r);
    r.tri_in = '{CMax, CMax, CMin, CMax, CMax, CMin}; rows.push_back(r);
    r.tri_in = '{32'sd0, 32'sd0, CMax, 32'sd0, CMax, 32'sd1}; rows.push_back(r);
    r.tri_in = '{32'sd0, 32'sd0, CMin, 32'sd1, CMax, 32'sd0}; rows.push_back(r);
    r.tri_in = '{32'sd65536, 32'sd0, 32'sd0, 32'sd65536, -32'sd65536, 32'sd0};
    rows.push_back(r);
    r.tri_in = '{32'sd3, 32'sd7, -32'sd5, 32'sd2, 32'sd9, -32'sd4}; rows.push_back(r);
    r.tri_in = '{32'sd0, 32'sd0, 32'sd1, 32'sd0, 32'sd0, 32'sd1}; rows.push_back(r);
    r.tri_in = '{32'sd0, 32'sd0, 32'sd3, 32'sd0, 32'sd0, 32'sd3}; rows.push_back(r);
    r.tri_in = '{32'shffffffff, 32'sh55555555, 32'shaaaaaaaa, 32'sd0,
                 32'sh12345678, CMin};
    rows.push_back(r);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i])
      send_triangle(rows[i].tri_in, rows[i].fixed, rows[i].res, $urandom_range(2));

    start <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);

    for (int i = 0; i < NumRandom; i++) begin
      t = rnd_triangle();
      w = ($urandom_range(3) == 0) ? $urandom_range(16) : 0;
      if ((i / 200) % 2 == 1) w = 0;
      send_triangle(t, 1'b0, '0, w);
      if (i == NumRandom / 2) begin
        start <= 1'b0;
        while (pending_q.size() != 0) @(posedge clk_i);
      end
    end
    start <= 1'b0;

    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("sent %0d triangles: %0d degenerate, %0d with saturated x", n_sent, n_degen,
             n_sat);
    $display("coverage: random, small, extreme, collinear and coincident point sets");
    if (errors == 0) begin
      $display("** circumcenter_2d: PASSED **");
    end else begin
      $display("** circumcenter_2d: FAILED **");
    end
    $finish;
  end

endmodule

### files.f
src/cc2_pkg.sv
src/cc2_geom.sv
src/cc2_numer.sv
src/cc2_div_step.sv
src/cc2_divider.sv
src/circumcenter_2d.sv
verif/tb_circumcenter_2d.sv
